FILE: rtl/core/cfp_pkg.sv
// Shared types, byte codes and result codes for the control frame parser.
`default_nettype none
package cfp_pkg;

  localparam int PREFIX_LEN_W = 5;
  localparam int FRAME_LEN_W = 12;
  localparam int CFG_DATA_W = 12;

  localparam logic [PREFIX_LEN_W-1:0] PREFIX_LIMIT_RST = 5'd15;
  localparam logic [FRAME_LEN_W-1:0] MAX_FRAME_LEN_RST = 12'd1550;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ENQ = 8'h05;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_DLE = 8'h10;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] PRINT_LO = 8'h21;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  localparam logic [1:0] KIND_PREFIX = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_BODY = 2'd2;
  localparam logic [1:0] KIND_END = 2'd3;

  localparam logic [2:0] MT_ENQ = 3'd0;
  localparam logic [2:0] MT_EOT = 3'd1;
  localparam logic [2:0] MT_ACK = 3'd2;
  localparam logic [2:0] MT_NAK = 3'd3;
  localparam logic [2:0] MT_INFO = 3'd4;
  localparam logic [2:0] MT_MALFORMED = 3'd5;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_CHECK = 2'd3;

  localparam logic CFG_PREFIX_LIMIT = 1'b0;
  localparam logic CFG_MAX_FRAME_LEN = 1'b1;

  typedef struct packed {
    logic [1:0] phase;
    logic [PREFIX_LEN_W-1:0] prefix_count;
    logic prefix_printable;
    logic [7:0] running_sum;
    logic [FRAME_LEN_W-1:0] frame_position;
  } parse_state_t;

  typedef struct packed {
    logic emit;
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] frame_type;
  } result_t;

  localparam parse_state_t STATE_RST = '{
    phase: PH_IDLE,
    prefix_count: '0,
    prefix_printable: 1'b1,
    running_sum: 8'd0,
    frame_position: '0
  };

endpackage
`default_nettype wire

FILE: rtl/core/cfp_step.sv
// Next-state and result logic for one received byte.
`default_nettype none
module cfp_step import cfp_pkg::*; (
  input wire parse_state_t cur,
  input wire logic [7:0] rx_byte,
  input wire logic [PREFIX_LEN_W-1:0] prefix_limit,
  input wire logic [FRAME_LEN_W-1:0] max_frame_len,
  output parse_state_t nxt,
  output result_t res
);

  logic is_start;
  logic printable;
  logic [FRAME_LEN_W:0] pos_inc;
  logic [7:0] want;

  assign is_start = rx_byte inside {CH_SOH, CH_STX, CH_EOT, CH_ENQ, CH_ACK, CH_DLE, CH_NAK};
  assign printable = (rx_byte >= PRINT_LO) && (rx_byte <= PRINT_HI);
  assign pos_inc = {1'b0, cur.frame_position} + {{FRAME_LEN_W{1'b0}}, 1'b1};
  assign want = cur.running_sum + 8'd1;

  always_comb begin
    nxt = cur;
    res = '{emit: 1'b0, kind: KIND_PREFIX, data: 8'd0, frame_type: MT_ENQ};
    case (cur.phase)
      PH_IDLE: begin
        if (!is_start) begin
          if (cur.prefix_count >= prefix_limit) begin
            nxt = STATE_RST;
            res = '{emit: 1'b1, kind: KIND_END, data: 8'd0, frame_type: MT_MALFORMED};
          end else begin
            nxt.prefix_count = cur.prefix_count + 1'b1;
            nxt.prefix_printable = cur.prefix_printable & printable;
            res = '{emit: 1'b1, kind: KIND_PREFIX, data: rx_byte, frame_type: MT_ENQ};
          end
        end else if (!cur.prefix_printable || rx_byte == CH_DLE) begin
          nxt = STATE_RST;
          res = '{emit: 1'b1, kind: KIND_END, data: 8'd0, frame_type: MT_MALFORMED};
        end else if (rx_byte == CH_ENQ || rx_byte == CH_EOT || rx_byte == CH_ACK ||
                     rx_byte == CH_NAK) begin
          nxt = STATE_RST;
          res.emit = 1'b1;
          res.kind = KIND_END;
          case (rx_byte)
            CH_ENQ: res.frame_type = MT_ENQ;
            CH_EOT: res.frame_type = MT_EOT;
            CH_ACK: res.frame_type = MT_ACK;
            default: res.frame_type = MT_NAK;
          endcase
        end else if (cur.prefix_count != '0) begin
          nxt = STATE_RST;
          res = '{emit: 1'b1, kind: KIND_END, data: 8'd0, frame_type: MT_MALFORMED};
        end else begin
          nxt.phase = (rx_byte == CH_SOH) ? PH_HEADER : PH_BODY;
          nxt.running_sum = 8'd0;
          nxt.frame_position = '0;
        end
      end
      PH_CHECK: begin
        nxt = STATE_RST;
        res = '{emit: 1'b1, kind: KIND_END, data: 8'd0,
                frame_type: (rx_byte == want) ? MT_INFO : MT_MALFORMED};
      end
      default: begin
        if (pos_inc > {1'b0, max_frame_len}) begin
          nxt = STATE_RST;
          res = '{emit: 1'b1, kind: KIND_END, data: 8'd0, frame_type: MT_MALFORMED};
        end else begin
          nxt.frame_position = pos_inc[FRAME_LEN_W-1:0];
          nxt.running_sum = cur.running_sum + rx_byte;
          if (cur.phase == PH_HEADER) begin
            if (rx_byte == CH_ETX) begin
              nxt = STATE_RST;
              res = '{emit: 1'b1, kind: KIND_END, data: 8'd0, frame_type: MT_MALFORMED};
            end else if (rx_byte == CH_STX) begin
              nxt.phase = PH_BODY;
            end else begin
              res = '{emit: 1'b1, kind: KIND_HEADER, data: rx_byte, frame_type: MT_ENQ};
            end
          end else if (rx_byte == CH_ETX) begin
            nxt.phase = PH_CHECK;
          end else begin
            res = '{emit: 1'b1, kind: KIND_BODY, data: rx_byte, frame_type: MT_ENQ};
          end
        end
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/cfp_result_reg.sv
// Result register that holds one tagged result until it is taken.
`default_nettype none
module cfp_result_reg import cfp_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic load,
  input wire result_t res,
  input wire logic res_ready,
  output logic res_valid,
  output logic [1:0] kind,
  output logic [7:0] data,
  output logic [2:0] frame_type
);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= res.emit;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.emit) begin
      kind <= res.kind;
      data <= res.data;
      frame_type <= res.frame_type;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/control_frame_parser.sv
// Control frame parser: splits a received byte stream into link frames and tags the prefix, header and body bytes.
`default_nettype none
// Each byte goes into an input register, is parsed combinationally against the frame state,
// and its result (if any) lands in a result register. A new byte is taken every cycle;
// the only stall is when the result register is full and not being taken, so one byte
// per cycle is sustained while res_ready stays high. The result register loads when the
// held byte advances, which waits while a held result is not taken.
// Configuration must be written while the parser idles.
module control_frame_parser import cfp_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic rx_valid,
  output logic rx_ready,
  input wire logic [7:0] rx_byte,
  output logic res_valid,
  input wire logic res_ready,
  output logic [1:0] kind,
  output logic [7:0] data,
  output logic [2:0] frame_type,
  input wire logic cfg_we,
  input wire logic cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [PREFIX_LEN_W-1:0] prefix_limit;
  logic [FRAME_LEN_W-1:0] max_frame_len;
  logic byte_valid;
  logic [7:0] byte_q;
  logic advance;
  parse_state_t state;
  parse_state_t state_next;
  result_t step_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_limit <= PREFIX_LIMIT_RST;
      max_frame_len <= MAX_FRAME_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PREFIX_LIMIT: prefix_limit <= cfg_data[PREFIX_LEN_W-1:0];
        default: max_frame_len <= cfg_data[FRAME_LEN_W-1:0];
      endcase
    end
  end

  assign advance = byte_valid && (!res_valid || res_ready);
  assign rx_ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx_ready) begin
      byte_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      byte_q <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RST;
    end else if (advance) begin
      state <= state_next;
    end
  end

  cfp_step u_step (
    .cur(state),
    .rx_byte(byte_q),
    .prefix_limit(prefix_limit),
    .max_frame_len(max_frame_len),
    .nxt(state_next),
    .res(step_res)
  );

  cfp_result_reg u_result (
    .clk(clk),
    .rst(rst),
    .load(advance),
    .res(step_res),
    .res_ready(res_ready),
    .res_valid(res_valid),
    .kind(kind),
    .data(data),
    .frame_type(frame_type)
  );

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> (byte_valid && res_valid && !res_ready))
    else $error("input stalled without a held result");

  a_restart_after_end: assert property (@(posedge clk) disable iff (rst)
    (advance && step_res.emit && step_res.kind == KIND_END) |=> (state == STATE_RST))
    else $error("parser did not restart after an end result");

  a_prefix_only_idle: assert property (@(posedge clk) disable iff (rst)
    (state.phase != PH_IDLE) |-> (state.prefix_count == '0))
    else $error("prefix count nonzero inside a frame");

endmodule
`default_nettype wire

FILE: sim/tb_control_frame_parser.sv
// Self-checking testbench for the control frame parser: byte requests in, tagged results checked.
`default_nettype none
module tb_control_frame_parser import cfp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rx_valid = 1'b0;
  logic rx_ready;
  logic [7:0] rx_byte = 8'h00;
  logic res_valid;
  logic res_ready = 1'b1;
  logic [1:0] kind;
  logic [7:0] data;
  logic [2:0] frame_type;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_PREFIX_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  control_frame_parser u_dut (
    .clk(clk),
    .rst(rst),
    .rx_valid(rx_valid),
    .rx_ready(rx_ready),
    .rx_byte(rx_byte),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .kind(kind),
    .data(data),
    .frame_type(frame_type),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [PREFIX_LEN_W-1:0] lim_prefix = PREFIX_LIMIT_RST;
  logic [FRAME_LEN_W-1:0] lim_frame = MAX_FRAME_LEN_RST;
  logic [1:0] ph = PH_IDLE;
  logic [PREFIX_LEN_W-1:0] pfx_cnt = '0;
  logic pfx_ok = 1'b1;
  logic [7:0] csum = 8'h00;
  logic [FRAME_LEN_W-1:0] fpos = '0;

  result_t tokens_due[$];
  int snd_idle = 0;
  int rcv_stall = 0;
  int errors = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int end_seen[6] = '{0, 0, 0, 0, 0, 0};
  int cycle_cnt = 0;

  function automatic bit is_intro(input logic [7:0] b);
    return b == CH_SOH || b == CH_STX || b == CH_EOT || b == CH_ENQ ||
           b == CH_ACK || b == CH_DLE || b == CH_NAK;
  endfunction

  function automatic void clear_frame();
    ph = PH_IDLE;
    pfx_cnt = '0;
    pfx_ok = 1'b1;
    csum = 8'h00;
    fpos = '0;
  endfunction

  function automatic result_t close_frame(input logic [2:0] mt);
    result_t r;
    clear_frame();
    r = '0;
    r.emit = 1'b1;
    r.kind = KIND_END;
    r.frame_type = mt;
    return r;
  endfunction

  function automatic result_t pass_byte(input logic [1:0] k, input logic [7:0] b);
    result_t r;
    r = '0;
    r.emit = 1'b1;
    r.kind = k;
    r.data = b;
    return r;
  endfunction

  function automatic result_t parse_byte(input logic [7:0] b);
    result_t r;
    logic [FRAME_LEN_W:0] nxt;
    logic [7:0] want;
    r = '0;
    case (ph)
      PH_IDLE: begin
        if (!is_intro(b)) begin
          if (pfx_cnt >= lim_prefix) begin
            r = close_frame(MT_MALFORMED);
          end else begin
            pfx_cnt = pfx_cnt + 1'b1;
            if (b < PRINT_LO || b > PRINT_HI) pfx_ok = 1'b0;
            r = pass_byte(KIND_PREFIX, b);
          end
        end else if (!pfx_ok || b == CH_DLE) begin
          r = close_frame(MT_MALFORMED);
        end else if (b == CH_ENQ) begin
          r = close_frame(MT_ENQ);
        end else if (b == CH_EOT) begin
          r = close_frame(MT_EOT);
        end else if (b == CH_ACK) begin
          r = close_frame(MT_ACK);
        end else if (b == CH_NAK) begin
          r = close_frame(MT_NAK);
        end else if (pfx_cnt != 0) begin
          r = close_frame(MT_MALFORMED);
        end else begin
          ph = (b == CH_SOH) ? PH_HEADER : PH_BODY;
          csum = 8'h00;
          fpos = '0;
        end
      end
      PH_CHECK: begin
        want = csum + 8'd1;
        r = close_frame((b == want) ? MT_INFO : MT_MALFORMED);
      end
      default: begin
        nxt = {1'b0, fpos} + 1'b1;
        if (nxt > {1'b0, lim_frame}) begin
          r = close_frame(MT_MALFORMED);
        end else begin
          fpos = nxt[FRAME_LEN_W-1:0];
          csum = csum + b;
          if (ph == PH_HEADER) begin
            if (b == CH_ETX) r = close_frame(MT_MALFORMED);
            else if (b == CH_STX) ph = PH_BODY;
            else r = pass_byte(KIND_HEADER, b);
          end else begin
            if (b == CH_ETX) ph = PH_CHECK;
            else r = pass_byte(KIND_BODY, b);
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= rcv_stall);
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && res_valid === 1'b1 && res_ready) begin
      if (tokens_due.size() == 0) begin
        flag_error($sformatf("unexpected result: kind %0d data %02h type %0d",
                             kind, data, frame_type));
      end else begin
        want = tokens_due[0];
        tokens_due.delete(0);
        results_checked++;
        if (want.kind == KIND_END) end_seen[want.frame_type]++;
        if (kind !== want.kind || data !== want.data || frame_type !== want.frame_type) begin
          flag_error($sformatf(
            "mismatch: expected kind %0d data %02h type %0d, got kind %0d data %02h type %0d",
            want.kind, want.data, want.frame_type, kind, data, frame_type));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_request(input logic [7:0] b);
    result_t r;
    if ($urandom_range(99) < snd_idle) begin
      rx_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (rx_ready !== 1'b1) @(posedge clk);
    r = parse_byte(b);
    if (r.emit) tokens_due.insert(tokens_due.size(), r);
    bytes_sent++;
  endtask

  task automatic settle();
    rx_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_PREFIX_LIMIT) lim_prefix = val[PREFIX_LEN_W-1:0];
    else lim_frame = val[FRAME_LEN_W-1:0];
    cfg_we <= 1'b0;
  endtask

  task automatic set_pacing(input int snd, input int rcv);
    snd_idle = snd;
    rcv_stall = rcv;
  endtask

  task automatic send_control(input int pfx_len, input bit clean, input logic [7:0] code);
    logic [7:0] b;
    int dirty_at;
    dirty_at = clean ? -1 : $urandom_range(0, pfx_len - 1);
    for (int i = 0; i < pfx_len; i++) begin
      if (i == dirty_at) begin
        do b = 8'($urandom_range(255));
        while (is_intro(b) || (b >= PRINT_LO && b <= PRINT_HI));
      end else begin
        b = 8'($urandom_range(PRINT_LO, PRINT_HI));
      end
      send_request(b);
    end
    send_request(code);
  endtask

  task automatic send_info_frame(input bit with_header, input bit good_check);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'h00;
    if (with_header) begin
      send_request(CH_SOH);
      repeat ($urandom_range(0, 5)) begin
        do b = 8'($urandom_range(255)); while (b == CH_STX || b == CH_ETX);
        send_request(b);
        sum = sum + b;
      end
      sum = sum + CH_STX;
    end
    send_request(CH_STX);
    repeat ($urandom_range(0, 8)) begin
      do b = 8'($urandom_range(255)); while (b == CH_ETX);
      send_request(b);
      sum = sum + b;
    end
    send_request(CH_ETX);
    sum = sum + CH_ETX + 8'd1;
    send_request(good_check ? sum : sum ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic run_traffic(input int n);
    int target;
    int pick;
    int pfx_len;
    logic [7:0] codes[4];
    codes = '{CH_ENQ, CH_EOT, CH_ACK, CH_NAK};
    target = bytes_sent + n;
    while (bytes_sent < target) begin
      pick = $urandom_range(99);
      pfx_len = ($urandom_range(3) == 0) ? $urandom_range(0, int'(lim_prefix) + 1)
                                         : $urandom_range(0, 3);
      if (pick < 40) begin
        send_control(pfx_len, 1'b1, codes[2'($urandom_range(3))]);
      end else if (pick < 80) begin
        send_info_frame(1'($urandom_range(1)), $urandom_range(9) != 0);
      end else if (pick < 87) begin
        send_control(pfx_len + 1, 1'b0, codes[2'($urandom_range(3))]);
      end else if (pick < 94) begin
        case ($urandom_range(2))
          0: begin
            send_request(8'($urandom_range(PRINT_LO, PRINT_HI)));
            send_request($urandom_range(1) ? CH_SOH : CH_STX);
          end
          1: begin
            send_request(CH_SOH);
            repeat ($urandom_range(0, 3)) send_request(8'($urandom_range(PRINT_LO, PRINT_HI)));
            send_request(CH_ETX);
          end
          default: send_control(pfx_len, 1'b1, CH_DLE);
        endcase
      end else begin
        repeat ($urandom_range(1, 4)) send_request(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_control_messages();
    send_request("A");
    send_request("~");
    send_request(CH_ENQ);
    send_request(CH_EOT);
    send_request(CH_ACK);
    send_request(CH_NAK);
    send_request(CH_DLE);
  endtask

  task automatic test_info_frames();
    send_request(CH_SOH);
    send_request(8'h00);
    send_request(CH_STX);
    send_request(8'hFF);
    send_request(CH_ETX);
    send_request(8'h05);
    send_request(CH_STX);
    send_request(CH_ETX);
    send_request(8'h04);
    send_request(CH_STX);
    send_request(8'h41);
    send_request(CH_ETX);
    send_request(8'h46);
  endtask

  task automatic test_malformed_openers();
    send_request(8'h7F);
    send_request(CH_ENQ);
    send_request("P");
    send_request(CH_SOH);
    send_request(CH_SOH);
    send_request(CH_ETX);
  endtask

  task automatic test_length_limits();
    write_cfg(CFG_PREFIX_LIMIT, 12'd0);
    send_request("Q");
    write_cfg(CFG_PREFIX_LIMIT, 12'd31);
    write_cfg(CFG_MAX_FRAME_LEN, 12'd0);
    send_request(CH_STX);
    send_request(8'h41);
    write_cfg(CFG_MAX_FRAME_LEN, 12'd4);
    send_request(CH_STX);
    send_request("a");
    send_request("b");
    send_request("c");
    send_request(CH_ETX);
    send_request(8'h2A);
    send_request(CH_STX);
    send_request("a");
    send_request("b");
    send_request("c");
    send_request("d");
    send_request(CH_ETX);
    write_cfg(CFG_MAX_FRAME_LEN, 12'hFFF);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_control_messages();
    test_info_frames();
    test_malformed_openers();
    test_length_limits();

    set_pacing(0, 0);
    run_traffic(200);
    write_cfg(CFG_PREFIX_LIMIT, {7'($urandom_range(127)), PREFIX_LIMIT_RST});
    write_cfg(CFG_MAX_FRAME_LEN, MAX_FRAME_LEN_RST);
    set_pacing(72, 0);
    run_traffic(200);
    write_cfg(CFG_PREFIX_LIMIT, 12'd0);
    write_cfg(CFG_MAX_FRAME_LEN, 12'd12);
    set_pacing(0, 72);
    run_traffic(150);
    write_cfg(CFG_PREFIX_LIMIT, {7'($urandom_range(127)), 5'($urandom_range(31))});
    write_cfg(CFG_MAX_FRAME_LEN, 12'($urandom_range(4, 40)));
    set_pacing(13, 13);
    run_traffic(250);
    settle();

    $display("Drove %0d byte requests over four pacing phases; %0d results checked, %0d errors.",
             bytes_sent, results_checked, errors);
    $display("Frame ends: ENQ %0d EOT %0d ACK %0d NAK %0d INFO %0d MALFORMED %0d",
             end_seen[MT_ENQ], end_seen[MT_EOT], end_seen[MT_ACK], end_seen[MT_NAK],
             end_seen[MT_INFO], end_seen[MT_MALFORMED]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
